// ===== sv/lbtt_pkg.sv =====
// ----------------------------------------------------------------------------
// lbtt_pkg
// Shared widths, constants, register indexes and control types for the light
// bearing top-two tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lbtt_pkg;

  localparam int W_ANGLE   = 8;
  localparam int W_SAMP    = 10;
  localparam int W_THR     = 12;
  localparam int W_GAIN    = 6;
  localparam int W_WEIGHT  = 11;
  localparam int W_SIDE    = 21;
  localparam int W_TOT     = 22;
  localparam int W_BEAR    = 16;
  localparam int W_GPROD   = W_GAIN + W_SIDE;
  localparam int W_Q       = 14;
  localparam int W_CNT     = $clog2(W_Q);
  localparam int W_CFG_IDX = 2;
  localparam int W_CFG_DAT = 12;

  localparam logic [W_WEIGHT-1:0]  MAX_WEIGHT  = 11'd1024;
  localparam logic [W_BEAR:0]      MAX_BEARING = 17'd46080;

  localparam logic [W_THR-1:0]     RST_THR     = 12'd300;
  localparam logic [W_GAIN-1:0]    RST_GAIN    = 6'd20;
  localparam logic [W_WEIGHT-1:0]  RST_WEIGHT  = 11'd717;

  localparam logic [W_CFG_IDX-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [W_CFG_IDX-1:0] CFG_GAIN      = 2'd1;
  localparam logic [W_CFG_IDX-1:0] CFG_WEIGHT    = 2'd2;

  // datapath commands, one per controller state
  typedef struct packed {
    logic load;
    logic wt_right;
    logic wt_left;
    logic total;
    logic mul;
    logic div_init;
    logic div_step;
    logic bear;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic pass;
    logic last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/lbtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbtt_ctrl
// Sequencer: one item through weighting, gain multiply, serial divide, clamp
// (those three only above threshold), kept-pair update, last-step hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lbtt_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  lbtt_pkg::sts_t      sts,
  output lbtt_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WR   = 4'd1;
  localparam logic [3:0] S_WL   = 4'd2;
  localparam logic [3:0] S_TOT  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_DIVI = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_BEAR = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  logic [3:0]                  state_r, state_nxt;
  logic [lbtt_pkg::W_CNT-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        cmd.wt_right = 1'b1;
        state_nxt    = S_WL;
      end
      S_WL: begin
        cmd.wt_left = 1'b1;
        state_nxt   = S_TOT;
      end
      S_TOT: begin
        cmd.total = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // below threshold: no bearing needed
        if (sts.pass) begin
          cmd.mul   = 1'b1;
          state_nxt = S_DIVI;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = lbtt_pkg::W_CNT'(lbtt_pkg::W_Q - 1);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_BEAR;
        end
      end
      S_BEAR: begin
        cmd.bear  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lbtt_dp.sv =====
// ----------------------------------------------------------------------------
// lbtt_dp
// Datapath: config registers, shared side-weight multiplier, gain multiplier,
// restoring divider, bearing clamp, kept top-two pair and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbtt_dp (
  input  wire                                clk,
  input  wire                                rst_n,
  input  lbtt_pkg::cmd_t                     cmd,
  output lbtt_pkg::sts_t                     sts,
  input  wire                                cfg_we,
  input  wire  [lbtt_pkg::W_CFG_IDX-1:0]     cfg_index,
  input  wire  [lbtt_pkg::W_CFG_DAT-1:0]     cfg_wdata,
  input  wire  [lbtt_pkg::W_ANGLE-1:0]       in_scan_angle,
  input  wire  [lbtt_pkg::W_SAMP-1:0]        in_right_near,
  input  wire  [lbtt_pkg::W_SAMP-1:0]        in_right_far,
  input  wire  [lbtt_pkg::W_SAMP-1:0]        in_left_near,
  input  wire  [lbtt_pkg::W_SAMP-1:0]        in_left_far,
  input  wire                                in_first_step,
  input  wire                                in_last_step,
  input  wire                                out_stall,
  output logic                               out_valid,
  output logic                               out_best_valid,
  output logic [lbtt_pkg::W_BEAR-1:0]        out_best_bearing,
  output logic [lbtt_pkg::W_TOT-1:0]         out_best_strength,
  output logic                               out_second_valid,
  output logic [lbtt_pkg::W_BEAR-1:0]        out_second_bearing,
  output logic [lbtt_pkg::W_TOT-1:0]         out_second_strength
);

  // configuration
  logic [lbtt_pkg::W_THR-1:0]    thr_r;
  logic [lbtt_pkg::W_GAIN-1:0]   gain_r;
  logic [lbtt_pkg::W_WEIGHT-1:0] weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= lbtt_pkg::RST_THR;
      gain_r   <= lbtt_pkg::RST_GAIN;
      weight_r <= lbtt_pkg::RST_WEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbtt_pkg::CFG_THRESHOLD: thr_r    <= cfg_wdata;
        lbtt_pkg::CFG_GAIN:      gain_r   <= cfg_wdata[lbtt_pkg::W_GAIN-1:0];
        lbtt_pkg::CFG_WEIGHT:    weight_r <= cfg_wdata[lbtt_pkg::W_WEIGHT-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [lbtt_pkg::W_ANGLE-1:0] angle_r;
  logic [lbtt_pkg::W_SAMP-1:0]  rn_r, rf_r, ln_r, lf_r;
  logic                         first_r, last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle_r <= in_scan_angle;
      rn_r    <= in_right_near;
      rf_r    <= in_right_far;
      ln_r    <= in_left_near;
      lf_r    <= in_left_far;
      first_r <= in_first_step;
      last_r  <= in_last_step;
    end
  end

  // side weighting, one shared multiplier
  logic [lbtt_pkg::W_WEIGHT-1:0] w_sat;
  logic [lbtt_pkg::W_SAMP-1:0]   near_s, far_s;
  logic [lbtt_pkg::W_SIDE-1:0]   far_prod, side_sum;
  logic [lbtt_pkg::W_SIDE-1:0]   right_r, left_r;

  assign w_sat    = (weight_r > lbtt_pkg::MAX_WEIGHT) ? lbtt_pkg::MAX_WEIGHT : weight_r;
  assign near_s   = cmd.wt_left ? ln_r : rn_r;
  assign far_s    = cmd.wt_left ? lf_r : rf_r;
  assign far_prod = lbtt_pkg::W_SIDE'(far_s) * lbtt_pkg::W_SIDE'(w_sat);
  assign side_sum = {1'b0, near_s, 10'd0} + far_prod;

  always_ff @(posedge clk) begin
    if (cmd.wt_right) begin
      right_r <= side_sum;
    end
    if (cmd.wt_left) begin
      left_r <= side_sum;
    end
  end

  // total, sign of imbalance, threshold test
  logic [lbtt_pkg::W_TOT-1:0]  total_r;
  logic [lbtt_pkg::W_SIDE-1:0] diff_r;
  logic                        neg_r, pass_r;
  logic [lbtt_pkg::W_TOT-1:0]  total_c;

  assign total_c = lbtt_pkg::W_TOT'(right_r) + lbtt_pkg::W_TOT'(left_r);

  always_ff @(posedge clk) begin
    if (cmd.total) begin
      total_r <= total_c;
      neg_r   <= right_r < left_r;
      diff_r  <= (right_r < left_r) ? (left_r - right_r) : (right_r - left_r);
      pass_r  <= total_c > {thr_r, 10'd0};
    end
  end

  // gain * diff, then restoring divide of (gain*diff*256) by total.
  // The quotient stays below 2^14, so the top 21 bits start as remainder.
  logic [lbtt_pkg::W_GPROD-1:0] gprod_r;
  logic [lbtt_pkg::W_TOT-1:0]   rem_r;
  logic [lbtt_pkg::W_Q-1:0]     num_lo_r;
  logic [lbtt_pkg::W_Q-1:0]     q_r;
  logic [lbtt_pkg::W_TOT:0]     rem_sh;
  logic                         q_bit;

  assign rem_sh = {rem_r, num_lo_r[lbtt_pkg::W_Q-1]};
  assign q_bit  = rem_sh >= {1'b0, total_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      gprod_r <= lbtt_pkg::W_GPROD'(gain_r) * lbtt_pkg::W_GPROD'(diff_r);
    end
    if (cmd.div_init) begin
      rem_r    <= {1'b0, gprod_r[lbtt_pkg::W_GPROD-1:6]};
      num_lo_r <= {gprod_r[5:0], 8'd0};
      q_r      <= '0;
    end else if (cmd.div_step) begin
      rem_r    <= q_bit ? lbtt_pkg::W_TOT'(rem_sh - {1'b0, total_r})
                        : rem_sh[lbtt_pkg::W_TOT-1:0];
      num_lo_r <= {num_lo_r[lbtt_pkg::W_Q-2:0], 1'b0};
      q_r      <= {q_r[lbtt_pkg::W_Q-2:0], q_bit};
    end
  end

  // bearing with clamp to 0..180 degrees; a sum past 180 clamps high on either sign
  logic [lbtt_pkg::W_BEAR-1:0] base, bearing_r;
  logic [lbtt_pkg::W_BEAR:0]   up_sum, dn_sum, bear_sum;

  assign base     = {angle_r, 8'd0};
  assign up_sum   = {1'b0, base} + (lbtt_pkg::W_BEAR + 1)'(q_r);
  assign dn_sum   = {1'b0, base} - (lbtt_pkg::W_BEAR + 1)'(q_r);
  assign bear_sum = neg_r ? dn_sum : up_sum;

  always_ff @(posedge clk) begin
    if (cmd.bear) begin
      if (neg_r && (lbtt_pkg::W_BEAR'(q_r) > base)) begin
        bearing_r <= '0;
      end else if (bear_sum > lbtt_pkg::MAX_BEARING) begin
        bearing_r <= lbtt_pkg::MAX_BEARING[lbtt_pkg::W_BEAR-1:0];
      end else begin
        bearing_r <= bear_sum[lbtt_pkg::W_BEAR-1:0];
      end
    end
  end

  // kept pair; first step clears it before this item counts
  logic                        top_valid_r, run_valid_r;
  logic [lbtt_pkg::W_BEAR-1:0] top_bear_r, run_bear_r;
  logic [lbtt_pkg::W_TOT-1:0]  top_str_r, run_str_r;
  logic                        tv, rv;
  logic [lbtt_pkg::W_BEAR-1:0] tb, rb;
  logic [lbtt_pkg::W_TOT-1:0]  ts, rs;

  assign tv = first_r ? 1'b0 : top_valid_r;
  assign tb = first_r ? '0   : top_bear_r;
  assign ts = first_r ? '0   : top_str_r;
  assign rv = first_r ? 1'b0 : run_valid_r;
  assign rb = first_r ? '0   : run_bear_r;
  assign rs = first_r ? '0   : run_str_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_valid_r <= 1'b0;
      top_bear_r  <= '0;
      top_str_r   <= '0;
      run_valid_r <= 1'b0;
      run_bear_r  <= '0;
      run_str_r   <= '0;
    end else if (cmd.update) begin
      top_valid_r <= tv;
      top_bear_r  <= tb;
      top_str_r   <= ts;
      run_valid_r <= rv;
      run_bear_r  <= rb;
      run_str_r   <= rs;
      if (pass_r) begin
        if (!tv || total_r > ts) begin
          run_valid_r <= tv;
          run_bear_r  <= tb;
          run_str_r   <= ts;
          top_valid_r <= 1'b1;
          top_bear_r  <= bearing_r;
          top_str_r   <= total_r;
        end else if (!rv || total_r > rs) begin
          run_valid_r <= 1'b1;
          run_bear_r  <= bearing_r;
          run_str_r   <= total_r;
        end
      end
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_best_valid      <= top_valid_r;
      out_best_bearing    <= top_valid_r ? top_bear_r : '0;
      out_best_strength   <= top_valid_r ? top_str_r  : '0;
      out_second_valid    <= run_valid_r;
      out_second_bearing  <= run_valid_r ? run_bear_r : '0;
      out_second_strength <= run_valid_r ? run_str_r  : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.pass     = pass_r;
  assign sts.last     = last_r;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

// ===== sv/light_bearing_top_two_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// light_bearing_top_two_tracker_unit
// Steps: accept, weight right, weight left, total; above threshold also gain
//   multiply, divide (one quotient bit per cycle) and clamp; then update and,
//   on a last step, result register. One item at a time. A held result blocks
//   only a last-step item, which waits to hand off until the output frees.
// Reset (rst_n low, synchronous): kept pair and out_valid cleared, registers
//   to threshold 300, gain 20, far weight 717.
// ----------------------------------------------------------------------------
`default_nettype none

module light_bearing_top_two_tracker_unit (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire  [lbtt_pkg::W_CFG_IDX-1:0]     cfg_index,
  input  wire  [lbtt_pkg::W_CFG_DAT-1:0]     cfg_wdata,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [lbtt_pkg::W_ANGLE-1:0]       in_scan_angle,
  input  wire  [lbtt_pkg::W_SAMP-1:0]        in_right_near,
  input  wire  [lbtt_pkg::W_SAMP-1:0]        in_right_far,
  input  wire  [lbtt_pkg::W_SAMP-1:0]        in_left_near,
  input  wire  [lbtt_pkg::W_SAMP-1:0]        in_left_far,
  input  wire                                in_first_step,
  input  wire                                in_last_step,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_best_valid,
  output logic [lbtt_pkg::W_BEAR-1:0]        out_best_bearing,
  output logic [lbtt_pkg::W_TOT-1:0]         out_best_strength,
  output logic                               out_second_valid,
  output logic [lbtt_pkg::W_BEAR-1:0]        out_second_bearing,
  output logic [lbtt_pkg::W_TOT-1:0]         out_second_strength
);

  lbtt_pkg::cmd_t cmd;
  lbtt_pkg::sts_t sts;

  lbtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbtt_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_scan_angle       (in_scan_angle),
    .in_right_near       (in_right_near),
    .in_right_far        (in_right_far),
    .in_left_near        (in_left_near),
    .in_left_far         (in_left_far),
    .in_first_step       (in_first_step),
    .in_last_step        (in_last_step),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_best_valid      (out_best_valid),
    .out_best_bearing    (out_best_bearing),
    .out_best_strength   (out_best_strength),
    .out_second_valid    (out_second_valid),
    .out_second_bearing  (out_second_bearing),
    .out_second_strength (out_second_strength)
  );

  // one item in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a second item back to back");

  // a runner-up never exists without a best
  a_second_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_second_valid |-> out_best_valid)
    else $error("second bearing without best bearing");

  a_invalid_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_best_valid |-> out_best_bearing == '0 && out_best_strength == '0)
    else $error("invalid best slot carries data");

  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_best_valid |->
      {1'b0, out_best_bearing} <= lbtt_pkg::MAX_BEARING)
    else $error("best bearing beyond 180 degrees");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_second_valid |-> out_second_strength <= out_best_strength)
    else $error("runner-up stronger than best");

endmodule

`default_nettype wire

// ===== tb/light_bearing_top_two_tracker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// light_bearing_top_two_tracker_unit_tb
// Self-checking bench for the top-two light bearing tracker. A directed table
// covers reset defaults, sample extremes, bearing clamps, threshold equality,
// strength ties and carry-over between scans. Random scans follow, under
// several register settings. Each report is checked against a typed table
// entry or an in-bench predictor; both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module light_bearing_top_two_tracker_unit_tb;

  localparam int N_PHASES      = 6;
  localparam int PHASE_STEPS   = 100;
  localparam int SETTLE_CYCLES = 30;
  localparam int IDLE_LIMIT    = 2000;
  localparam int REPORT_MAX    = 10;

  typedef enum int {S_HIGH, S_LOW, S_RAIL, S_ANY} sample_mode_t;

  typedef struct packed {
    logic [lbtt_pkg::W_ANGLE-1:0] scan_angle;
    logic [lbtt_pkg::W_SAMP-1:0]  right_near;
    logic [lbtt_pkg::W_SAMP-1:0]  right_far;
    logic [lbtt_pkg::W_SAMP-1:0]  left_near;
    logic [lbtt_pkg::W_SAMP-1:0]  left_far;
    logic                         first_step;
    logic                         last_step;
  } scan_step_t;

  typedef struct packed {
    logic                        best_ok;
    logic [lbtt_pkg::W_BEAR-1:0] best_brg;
    logic [lbtt_pkg::W_TOT-1:0]  best_str;
    logic                        sec_ok;
    logic [lbtt_pkg::W_BEAR-1:0] sec_brg;
    logic [lbtt_pkg::W_TOT-1:0]  sec_str;
  } scan_report_t;

  typedef struct {
    scan_step_t   step;
    bit           typed;
    scan_report_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [lbtt_pkg::W_CFG_IDX-1:0] cfg_index = lbtt_pkg::CFG_THRESHOLD;
  logic [lbtt_pkg::W_CFG_DAT-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [lbtt_pkg::W_ANGLE-1:0] in_scan_angle = '0;
  logic [lbtt_pkg::W_SAMP-1:0] in_right_near = '0;
  logic [lbtt_pkg::W_SAMP-1:0] in_right_far = '0;
  logic [lbtt_pkg::W_SAMP-1:0] in_left_near = '0;
  logic [lbtt_pkg::W_SAMP-1:0] in_left_far = '0;
  logic in_first_step = 1'b0;
  logic in_last_step = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_best_valid;
  logic [lbtt_pkg::W_BEAR-1:0] out_best_bearing;
  logic [lbtt_pkg::W_TOT-1:0] out_best_strength;
  logic out_second_valid;
  logic [lbtt_pkg::W_BEAR-1:0] out_second_bearing;
  logic [lbtt_pkg::W_TOT-1:0] out_second_strength;

  light_bearing_top_two_tracker_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_scan_angle       (in_scan_angle),
    .in_right_near       (in_right_near),
    .in_right_far        (in_right_far),
    .in_left_near        (in_left_near),
    .in_left_far         (in_left_far),
    .in_first_step       (in_first_step),
    .in_last_step        (in_last_step),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_best_valid      (out_best_valid),
    .out_best_bearing    (out_best_bearing),
    .out_best_strength   (out_best_strength),
    .out_second_valid    (out_second_valid),
    .out_second_bearing  (out_second_bearing),
    .out_second_strength (out_second_strength)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of registers and kept pair
  logic [lbtt_pkg::W_THR-1:0]    thr_reg    = lbtt_pkg::RST_THR;
  logic [lbtt_pkg::W_GAIN-1:0]   gain_reg   = lbtt_pkg::RST_GAIN;
  logic [lbtt_pkg::W_WEIGHT-1:0] weight_reg = lbtt_pkg::RST_WEIGHT;
  logic [lbtt_pkg::W_BEAR-1:0]   lead_brg = '0, trail_brg = '0;
  logic [lbtt_pkg::W_TOT-1:0]    lead_str = '0, trail_str = '0;
  logic                          lead_ok = 1'b0, trail_ok = 1'b0;

  scan_report_t expected_reports[$];
  dir_row_t     dir_rows[$];
  int unsigned  errors = 0;
  int unsigned  steps_sent = 0;
  int unsigned  reports_checked = 0;
  int unsigned  burst_left = 0;
  int unsigned  idle_cycles = 0;

  function automatic logic [lbtt_pkg::W_TOT-1:0] side_sum(
      logic [lbtt_pkg::W_SAMP-1:0] near_s, logic [lbtt_pkg::W_SAMP-1:0] far_s,
      logic [lbtt_pkg::W_WEIGHT-1:0] w);
    return lbtt_pkg::W_TOT'(near_s) * lbtt_pkg::W_TOT'(1024) +
           lbtt_pkg::W_TOT'(far_s) * lbtt_pkg::W_TOT'(w);
  endfunction

  task automatic track_step(input scan_step_t s, output bit emits,
                            output scan_report_t rep);
    logic [lbtt_pkg::W_WEIGHT-1:0] w;
    logic [lbtt_pkg::W_TOT-1:0] right_w, left_w, total, diff;
    longint unsigned mag;
    longint brg;
    w = (weight_reg > lbtt_pkg::MAX_WEIGHT) ? lbtt_pkg::MAX_WEIGHT : weight_reg;
    right_w = side_sum(s.right_near, s.right_far, w);
    left_w = side_sum(s.left_near, s.left_far, w);
    total = right_w + left_w;
    if (s.first_step) begin
      {lead_ok, lead_brg, lead_str} = '0;
      {trail_ok, trail_brg, trail_str} = '0;
    end
    if (64'(total) > 64'(thr_reg) * 64'd1024) begin
      diff = (right_w >= left_w) ? right_w - left_w : left_w - right_w;
      mag = (64'(gain_reg) * 64'(diff) * 64'd256) / 64'(total);
      brg = longint'(s.scan_angle) * 256;
      brg = (right_w < left_w) ? brg - longint'(mag) : brg + longint'(mag);
      if (brg < 0) brg = 0;
      if (brg > longint'(lbtt_pkg::MAX_BEARING)) brg = longint'(lbtt_pkg::MAX_BEARING);
      if (!lead_ok || total > lead_str) begin
        {trail_ok, trail_brg, trail_str} = {lead_ok, lead_brg, lead_str};
        {lead_ok, lead_brg, lead_str} = {1'b1, lbtt_pkg::W_BEAR'(brg), total};
      end else if (!trail_ok || total > trail_str) begin
        {trail_ok, trail_brg, trail_str} = {1'b1, lbtt_pkg::W_BEAR'(brg), total};
      end
    end
    emits = s.last_step;
    rep = '0;
    if (lead_ok) {rep.best_ok, rep.best_brg, rep.best_str} = {1'b1, lead_brg, lead_str};
    if (trail_ok) {rep.sec_ok, rep.sec_brg, rep.sec_str} = {1'b1, trail_brg, trail_str};
  endtask

  function automatic scan_step_t mk_step(int a, int rn, int rf, int ln, int lf,
                                        bit f, bit l);
    scan_step_t s;
    s.scan_angle = lbtt_pkg::W_ANGLE'(a);
    s.right_near = lbtt_pkg::W_SAMP'(rn);
    s.right_far  = lbtt_pkg::W_SAMP'(rf);
    s.left_near  = lbtt_pkg::W_SAMP'(ln);
    s.left_far   = lbtt_pkg::W_SAMP'(lf);
    s.first_step = f;
    s.last_step  = l;
    return s;
  endfunction

  function automatic scan_report_t mk_report(bit bv, int bb, int bs, bit sv, int sb, int ss);
    return {bv, lbtt_pkg::W_BEAR'(bb), lbtt_pkg::W_TOT'(bs),
            sv, lbtt_pkg::W_BEAR'(sb), lbtt_pkg::W_TOT'(ss)};
  endfunction

  task automatic add_row(input scan_step_t s, input bit typed, input scan_report_t want);
    dir_row_t r;
    r.step = s;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  function automatic logic [lbtt_pkg::W_SAMP-1:0] pick_sample(sample_mode_t mode);
    case (mode)
      S_HIGH:  return lbtt_pkg::W_SAMP'($urandom_range(900, 1023));
      S_LOW:   return lbtt_pkg::W_SAMP'($urandom_range(0, 40));
      S_RAIL:  return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
      default: return lbtt_pkg::W_SAMP'($urandom_range(0, 1023));
    endcase
  endfunction

  // sender runs in bursts; a gap between bursts drops valid
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drive_step(input scan_step_t s, input bit typed, input scan_report_t want);
    bit emits;
    scan_report_t rep;
    in_valid      <= 1'b1;
    in_scan_angle <= s.scan_angle;
    in_right_near <= s.right_near;
    in_right_far  <= s.right_far;
    in_left_near  <= s.left_near;
    in_left_far   <= s.left_far;
    in_first_step <= s.first_step;
    in_last_step  <= s.last_step;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_step(s, emits, rep);
    if (emits) expected_reports.push_back(typed ? want : rep);
    steps_sent++;
  endtask

  // block may still be busy on a step that reports nothing
  task automatic settle();
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [lbtt_pkg::W_THR-1:0] thr,
                            input logic [lbtt_pkg::W_GAIN-1:0] gain,
                            input logic [lbtt_pkg::W_WEIGHT-1:0] wt);
    cfg_we    <= 1'b1;
    cfg_index <= lbtt_pkg::CFG_THRESHOLD;
    cfg_wdata <= lbtt_pkg::W_CFG_DAT'(thr);
    @(posedge clk);
    cfg_index <= lbtt_pkg::CFG_GAIN;
    cfg_wdata <= lbtt_pkg::W_CFG_DAT'(gain);
    @(posedge clk);
    cfg_index <= lbtt_pkg::CFG_WEIGHT;
    cfg_wdata <= lbtt_pkg::W_CFG_DAT'(wt);
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_reg = thr;
    gain_reg = gain;
    weight_reg = wt;
  endtask

  task automatic flag_error(input string what, input scan_report_t want,
                            input scan_report_t got);
    errors++;
    if (errors <= REPORT_MAX)
      $display("%0t %s: want %0d/%0d/%0d %0d/%0d/%0d got %0d/%0d/%0d %0d/%0d/%0d",
               $realtime, what,
               want.best_ok, want.best_brg, want.best_str,
               want.sec_ok, want.sec_brg, want.sec_str,
               got.best_ok, got.best_brg, got.best_str,
               got.sec_ok, got.sec_brg, got.sec_str);
  endtask

  // receiver stall pattern: period and duty re-picked on a free-running count, often none
  int unsigned stall_cyc = 0, stall_period = 4, stall_duty = 0;
  always @(posedge clk) begin
    stall_cyc++;
    if (stall_cyc % 200 == 0) begin
      stall_period = $urandom_range(2, 16);
      stall_duty = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, stall_period - 1);
    end
    out_stall <= (stall_cyc % stall_period) < stall_duty;
  end

  scan_report_t got_rep, want_rep;
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got_rep = {out_best_valid, out_best_bearing, out_best_strength,
                 out_second_valid, out_second_bearing, out_second_strength};
      if (expected_reports.size() == 0) begin
        flag_error("report with no scan pending", '0, got_rep);
      end else begin
        want_rep = expected_reports.pop_front();
        reports_checked++;
        if (got_rep.best_ok !== want_rep.best_ok || got_rep.best_brg !== want_rep.best_brg ||
            got_rep.best_str !== want_rep.best_str || got_rep.sec_ok !== want_rep.sec_ok ||
            got_rep.sec_brg !== want_rep.sec_brg || got_rep.sec_str !== want_rep.sec_str)
          flag_error("report mismatch", want_rep, got_rep);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles, %0d reports outstanding",
               IDLE_LIMIT, expected_reports.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    scan_step_t s, prev;
    logic [lbtt_pkg::W_THR-1:0] thr;
    logic [lbtt_pkg::W_GAIN-1:0] gain;
    logic [lbtt_pkg::W_WEIGHT-1:0] wt;
    sample_mode_t rmode, lmode;
    int unsigned n, len, a0, stride, a;

    // defaults: threshold 300, gain 20, far weight 717
    add_row(mk_step(90, 0, 0, 0, 0, 1, 1), 1, mk_report(0, 0, 0, 0, 0, 0));
    add_row(mk_step(180, 1023, 1023, 1023, 1023, 1, 1), 1,
            mk_report(1, 46080, 3562086, 0, 0, 0));
    // angle past 180 and full right swing clamp high, full left swing clamps low
    add_row(mk_step(255, 1023, 0, 0, 0, 1, 1), 1, mk_report(1, 46080, 1047552, 0, 0, 0));
    add_row(mk_step(0, 0, 0, 1023, 0, 1, 1), 1, mk_report(1, 0, 1047552, 0, 0, 0));
    // total equal to threshold does not count, one far count above does
    add_row(mk_step(90, 300, 0, 0, 0, 1, 1), 1, mk_report(0, 0, 0, 0, 0, 0));
    add_row(mk_step(90, 300, 1, 0, 0, 1, 1), 1, mk_report(1, 28160, 307917, 0, 0, 0));
    // scan with ties against both kept strengths
    add_row(mk_step(30, 500, 200, 400, 100, 1, 0), 0, '0);
    add_row(mk_step(60, 800, 800, 100, 50, 0, 0), 0, '0);
    add_row(mk_step(90, 100, 50, 800, 800, 0, 0), 0, '0);
    add_row(mk_step(120, 500, 200, 400, 100, 0, 0), 0, '0);
    add_row(mk_step(150, 100, 50, 800, 800, 0, 1), 0, '0);
    // no first step: pair carries over, and survives an emit
    add_row(mk_step(45, 1023, 1023, 1023, 1000, 0, 1), 0, '0);
    add_row(mk_step(100, 0, 0, 0, 0, 0, 1), 0, '0);
    add_row(mk_step(170, 'h2AA, 'h155, 'h2AA, 'h155, 1, 0), 0, '0);
    add_row(mk_step(85, 'h155, 'h2AA, 'h155, 'h2AA, 0, 1), 0, '0);
    add_row(mk_step(0, 1, 1, 1, 1, 1, 0), 0, '0);
    add_row(mk_step(179, 700, 0, 650, 0, 0, 1), 0, '0);
    // angle past 180 with left heavier still clamps high
    add_row(mk_step(255, 0, 0, 400, 0, 1, 1), 0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      pace();
      drive_step(dir_rows[i].step, dir_rows[i].typed, dir_rows[i].want);
    end
    in_valid <= 1'b0;

    prev = '0;
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      case (p)
        0:       begin thr = 12'd0;    gain = 6'd63; wt = 11'd1024; end
        1:       begin thr = 12'd3479; gain = 6'd1;  wt = 11'd2047; end
        2:       begin thr = 12'd4095; gain = 6'd0;  wt = 11'd0;    end
        3:       begin thr = 12'd1;    gain = 6'd0;  wt = 11'd1025; end
        4: begin
          thr = lbtt_pkg::W_THR'($urandom_range(0, 1500));
          gain = lbtt_pkg::W_GAIN'($urandom_range(0, 63));
          wt = lbtt_pkg::W_WEIGHT'($urandom_range(0, 2047));
        end
        default: begin
          thr = lbtt_pkg::W_THR'($urandom_range(0, 4095));
          gain = lbtt_pkg::W_GAIN'($urandom_range(0, 63));
          wt = lbtt_pkg::W_WEIGHT'($urandom_range(0, 1024));
        end
      endcase
      write_regs(thr, gain, wt);
      n = 0;
      while (n < PHASE_STEPS) begin
        // mostly whole scans, the rest stray steps with random framing
        len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 10) : 1;
        a0 = $urandom_range(0, 180);
        stride = $urandom_range(0, 30);
        for (int k = 0; k < len; k++) begin
          rmode = sample_mode_t'($urandom_range(0, 4));
          lmode = ($urandom_range(0, 2) == 0) ? rmode : sample_mode_t'($urandom_range(0, 4));
          a = a0 + k * stride;
          s.scan_angle = (a > 255) ? 8'd255 : lbtt_pkg::W_ANGLE'(a);
          s.right_near = pick_sample(rmode);
          s.right_far  = pick_sample(rmode);
          s.left_near  = pick_sample(lmode);
          s.left_far   = pick_sample(lmode);
          if (k > 0 && $urandom_range(0, 6) == 0) begin
            // same total as the step before, sides maybe swapped
            if ($urandom_range(0, 1) != 0)
              {s.right_near, s.right_far, s.left_near, s.left_far} =
                {prev.left_near, prev.left_far, prev.right_near, prev.right_far};
            else
              {s.right_near, s.right_far, s.left_near, s.left_far} =
                {prev.right_near, prev.right_far, prev.left_near, prev.left_far};
          end
          if (len == 1) begin
            s.scan_angle = lbtt_pkg::W_ANGLE'($urandom_range(0, 255));
            s.first_step = 1'($urandom_range(0, 1));
            s.last_step = 1'($urandom_range(0, 1));
          end else begin
            s.first_step = (k == 0);
            s.last_step = (k == len - 1);
          end
          pace();
          drive_step(s, 0, '0);
          prev = s;
          n++;
        end
      end
      in_valid <= 1'b0;
    end

    settle();
    $display("Ran %0d scan steps over %0d register settings, defaults included.",
             steps_sent, N_PHASES + 1);
    $display("Checked %0d reports; %0d mismatches.", reports_checked, errors);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== light_bearing_top_two_tracker_unit.f =====
sv/lbtt_pkg.sv
sv/lbtt_ctrl.sv
sv/lbtt_dp.sv
sv/light_bearing_top_two_tracker_unit.sv
tb/light_bearing_top_two_tracker_unit_tb.sv
